// File: rtl/bounded_deque_with_search_unit_assert.svh
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef BOUNDED_DEQUE_WITH_SEARCH_UNIT_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication
`define BDQS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BDQS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bdqs_pkg.sv
`timescale 1ns / 1ps
package bdqs_pkg;

    localparam int BDQS_CAPACITY = 16;
    localparam int WORD_W        = 32;
    localparam int OP_W          = 3;
    localparam int COUNT_OUT_W   = 5;

    localparam logic [WORD_W-1:0] MOST_NEG_WORD = 32'h8000_0000;

    localparam logic [OP_W-1:0] OP_ADD_BACK    = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_FRONT   = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_BACK = 3'd2;
    localparam logic [OP_W-1:0] OP_CONTAINS    = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR       = 3'd4;

    // back of the queue sits in cell 0, front at cell (count - 1)
    typedef struct packed {
        logic              shift_in;
        logic              shift_out;
        logic              write_front;
        logic [WORD_W-1:0] word;
    } bdqs_ctrl_t;

endpackage

// File: rtl/bdqs_cell.sv
`timescale 1ns / 1ps
module bdqs_cell
    import bdqs_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
)
(
    input  logic              clk,
    input  bdqs_ctrl_t        ctrl,
    input  logic [CNT_W-1:0]  count,
    input  logic [WORD_W-1:0] from_back,
    input  logic [WORD_W-1:0] from_front,
    output logic [WORD_W-1:0] data,
    output logic              match
);

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic              occupied;

    assign occupied = CNT_W'(INDEX) < count;

    always_comb
    begin
        priority if (ctrl.shift_in)
        begin
            data_next = from_back;
        end
        else if (ctrl.shift_out)
        begin
            data_next = from_front;
        end
        else if (ctrl.write_front && (count == CNT_W'(INDEX)))
        begin
            data_next = ctrl.word;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = occupied && (data_reg == ctrl.word);

endmodule

// File: rtl/bounded_deque_with_search_unit.sv
`timescale 1ns / 1ps
// Bounded double-ended queue of signed 32-bit words with a membership search, built as a row
// of CAPACITY cells. One operation beat is taken per clock cycle and its result beat appears
// in the cycle after acceptance from an output register; the input stays ready while that
// register is empty or being drained, so the sustained rate is one item per cycle. Every
// operation completes on acceptance: appends at the back shift the row, inserts at the
// front write the cell at the current count, removes read cell 0 and shift back, and the
// search compares every cell in parallel and ORs the hits. No clearing pass follows reset.
module bounded_deque_with_search_unit
    import bdqs_pkg::*;
#(
    parameter int CAPACITY = BDQS_CAPACITY
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value
    input  logic [2:0]  s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // removed_value, element_count, zero fill
    output logic [2:0]  m_axis_tuser    // found, is_empty, rejected
);

`include "bounded_deque_with_search_unit_assert.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic [WORD_W-1:0] removed_reg;
    logic [WORD_W-1:0] removed_next;
    logic              found_reg;
    logic              found_next;
    logic [COUNT_OUT_W-1:0] count_out_reg;
    logic              empty_reg;
    logic              rejected_reg;
    logic              rejected_next;

    logic              in_fire;
    logic              is_full;
    logic              is_none;
    logic [OP_W-1:0]   op;
    bdqs_ctrl_t        ctrl;
    logic [WORD_W-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0] cell_match;
    logic [CNT_W+COUNT_OUT_W-1:0] count_wide;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign op            = s_axis_tuser;
    assign is_full       = count_reg == CNT_W'(CAPACITY);
    assign is_none       = count_reg == '0;
    assign found_next    = (op == OP_CONTAINS) && (|cell_match);

    always_comb
    begin
        ctrl.shift_in    = 1'b0;
        ctrl.shift_out   = 1'b0;
        ctrl.write_front = 1'b0;
        ctrl.word        = s_axis_tdata;
        count_next       = count_reg;
        removed_next     = MOST_NEG_WORD;
        rejected_next    = 1'b0;
        unique case (op)
            OP_ADD_BACK:
            begin
                if (is_full)
                begin
                    rejected_next = 1'b1;
                end
                else
                begin
                    ctrl.shift_in = in_fire;
                    count_next    = count_reg + 1'b1;
                end
            end
            OP_ADD_FRONT:
            begin
                if (is_full)
                begin
                    rejected_next = 1'b1;
                end
                else
                begin
                    ctrl.write_front = in_fire;
                    count_next       = count_reg + 1'b1;
                end
            end
            OP_REMOVE_BACK:
            begin
                if (is_none)
                begin
                    rejected_next = 1'b1;
                end
                else
                begin
                    ctrl.shift_out = in_fire;
                    removed_next   = cell_data[0];
                    count_next     = count_reg - 1'b1;
                end
            end
            OP_CONTAINS:
            begin
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [WORD_W-1:0] back_side;
            logic [WORD_W-1:0] front_side;
            if (gi == 0)
            begin : g_first
                assign back_side = s_axis_tdata;
            end
            else
            begin : g_mid
                assign back_side = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign front_side = cell_data[gi];
            end
            else
            begin : g_inner
                assign front_side = cell_data[gi+1];
            end
            bdqs_cell #(
                .INDEX (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .count      (count_reg),
                .from_back  (back_side),
                .from_front (front_side),
                .data       (cell_data[gi]),
                .match      (cell_match[gi])
            );
        end
    endgenerate

    assign count_wide = {{COUNT_OUT_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            removed_reg   <= removed_next;
            found_reg     <= found_next;
            count_out_reg <= count_wide[COUNT_OUT_W-1:0];
            empty_reg     <= count_next == '0;
            rejected_reg  <= rejected_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, count_out_reg, removed_reg};
    assign m_axis_tuser  = {rejected_reg, empty_reg, found_reg};

    `BDQS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `BDQS_ASSERT_NOW(a_reject_word, out_valid_reg && rejected_reg,
        removed_reg == MOST_NEG_WORD && !found_reg, "rejected beat carries data")
    `BDQS_ASSERT_NEXT(a_push_count, in_fire && op == OP_ADD_BACK && !is_full,
        count_reg == CNT_W'($past(count_reg) + 1'b1), "append did not grow count")
    `BDQS_ASSERT_NEXT(a_found_op, in_fire && op != OP_CONTAINS,
        !found_reg, "found raised outside a search")

endmodule
